@@ rtl/pams_pkg.sv @@
// ---------------------------------------------------------------------------
// Pick arm motion sequencer package
// Shared types, constants and helper functions for the sequencer core.
// ---------------------------------------------------------------------------
package pams_pkg;

  localparam int unsigned ServoW  = 11;
  localparam int unsigned PickW   = 8;
  localparam int unsigned TickW   = 11;
  localparam int unsigned ZPwmW   = 15;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 11;

  localparam logic [ServoW-1:0] ServoStep  = 11'd10;
  localparam logic [ServoW-1:0] ServoFull  = 11'd2047;
  localparam logic [TickW-1:0]  ShortLimit = 11'd30;
  localparam logic [ZPwmW-1:0]  ZStopCmp   = 15'd10000;
  localparam logic [ZPwmW-1:0]  ZFwdCmp    = 15'd0;
  localparam logic [ZPwmW-1:0]  ZBackCmp   = 15'd20000;

  localparam logic [ServoW-1:0] ServoMaxRst  = 11'd1600;
  localparam logic [ServoW-1:0] ServoMinRst  = 11'd1400;
  localparam logic [PickW-1:0]  PickTimeRst  = 8'd14;
  localparam logic [ServoW-1:0] ServoRestRst = 11'd1500;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SERVO_MAX  = 2'd0,
    CFG_SERVO_MIN  = 2'd1,
    CFG_PICK_TIME  = 2'd2,
    CFG_SERVO_REST = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    Z_STOP = 2'd0,
    Z_FWD  = 2'd1,
    Z_BACK = 2'd2
  } z_dir_e;

  // Sequence phases, one-hot. The numeric phase shown at the output is
  // derived by phase_code().
  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_FWD  = 6'b000010,
    PH_GRIP = 6'b000100,
    PH_BACK = 6'b001000,
    PH_LIFT = 6'b010000,
    PH_REST = 6'b100000
  } phase_e;

  localparam logic [PhaseW-1:0] PhaseCodeIdle = 3'd0;
  localparam logic [PhaseW-1:0] PhaseCodeFwd  = 3'd2;
  localparam logic [PhaseW-1:0] PhaseCodeGrip = 3'd3;
  localparam logic [PhaseW-1:0] PhaseCodeBack = 3'd4;
  localparam logic [PhaseW-1:0] PhaseCodeLift = 3'd5;
  localparam logic [PhaseW-1:0] PhaseCodeRest = 3'd6;

  typedef struct packed {
    logic [ServoW-1:0] servo_max;
    logic [ServoW-1:0] servo_min;
    logic [PickW-1:0]  pick_time;
    logic [ServoW-1:0] servo_rest;
  } cfg_t;

  typedef struct packed {
    phase_e            phase;
    logic [TickW-1:0]  tick;
    logic [ServoW-1:0] servo;
    z_dir_e            z_dir;
  } seq_state_t;

  typedef struct packed {
    logic [ServoW-1:0] servo_pwm;
    logic [ZPwmW-1:0]  z_pwm;
    logic [1:0]        z_dir;
    logic [PhaseW-1:0] phase;
    logic              busy;
  } result_t;

  function automatic logic [PhaseW-1:0] phase_code(phase_e ph);
    logic [PhaseW-1:0] code;
    case (ph)
      PH_FWD:  code = PhaseCodeFwd;
      PH_GRIP: code = PhaseCodeGrip;
      PH_BACK: code = PhaseCodeBack;
      PH_LIFT: code = PhaseCodeLift;
      PH_REST: code = PhaseCodeRest;
      default: code = PhaseCodeIdle;
    endcase
    return code;
  endfunction

  function automatic logic [ZPwmW-1:0] z_compare(z_dir_e dir);
    logic [ZPwmW-1:0] cmp;
    case (dir)
      Z_FWD:   cmp = ZFwdCmp;
      Z_BACK:  cmp = ZBackCmp;
      default: cmp = ZStopCmp;
    endcase
    return cmp;
  endfunction

endpackage

@@ rtl/pams_cfg.sv @@
// ---------------------------------------------------------------------------
// Pick arm motion sequencer configuration registers
// Holds the servo bounds, rest value and Z travel unit written by the host.
// ---------------------------------------------------------------------------
module pams_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pams_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pams_pkg::CfgDatW-1:0]  cfg_data_i,
  output pams_pkg::cfg_t                cfg_o
);

  pams_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (pams_pkg::cfg_idx_e'(cfg_index_i))
        pams_pkg::CFG_SERVO_MAX:  cfg_d.servo_max  = cfg_data_i;
        pams_pkg::CFG_SERVO_MIN:  cfg_d.servo_min  = cfg_data_i;
        pams_pkg::CFG_PICK_TIME:  cfg_d.pick_time  = cfg_data_i[pams_pkg::PickW-1:0];
        pams_pkg::CFG_SERVO_REST: cfg_d.servo_rest = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.servo_max  <= pams_pkg::ServoMaxRst;
      cfg_q.servo_min  <= pams_pkg::ServoMinRst;
      cfg_q.pick_time  <= pams_pkg::PickTimeRst;
      cfg_q.servo_rest <= pams_pkg::ServoRestRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/pams_step.sv @@
// ---------------------------------------------------------------------------
// Pick arm motion sequencer tick logic
// Computes the next sequence state and the result of one tick.
// ---------------------------------------------------------------------------
module pams_step (
  input  pams_pkg::cfg_t       cfg_i,
  input  pams_pkg::seq_state_t state_i,
  input  logic                 start_i,
  output pams_pkg::seq_state_t state_o,
  output pams_pkg::result_t    res_o
);

  logic [pams_pkg::TickW-1:0]  travel;
  logic [pams_pkg::TickW-1:0]  limit;
  logic [pams_pkg::TickW-1:0]  tick_inc;
  logic                        tick_end;
  logic [pams_pkg::ServoW:0]   up_sum;
  logic [pams_pkg::ServoW-1:0] up_val;
  logic [pams_pkg::ServoW-1:0] down_val;
  logic [pams_pkg::ServoW-1:0] up_bound;
  logic [pams_pkg::ServoW-1:0] down_bound;
  pams_pkg::seq_state_t        nxt;

  // Travel time is pick_time * 5, formed as a shift and add.
  assign travel = {1'b0, cfg_i.pick_time, 2'b00} + {3'b000, cfg_i.pick_time};

  assign limit = (state_i.phase == pams_pkg::PH_FWD || state_i.phase == pams_pkg::PH_BACK)
               ? travel : pams_pkg::ShortLimit;

  assign tick_inc = state_i.tick + 1'b1;
  assign tick_end = tick_inc > limit;

  // Ramp steps are taken only while still on the near side of the bound.
  assign up_bound   = cfg_i.servo_max;
  assign down_bound = (state_i.phase == pams_pkg::PH_REST) ? cfg_i.servo_rest
                                                           : cfg_i.servo_min;
  assign up_sum = {1'b0, state_i.servo} + {1'b0, pams_pkg::ServoStep};
  assign up_val = up_sum[pams_pkg::ServoW] ? pams_pkg::ServoFull
                                           : up_sum[pams_pkg::ServoW-1:0];
  assign down_val = (state_i.servo >= pams_pkg::ServoStep)
                  ? state_i.servo - pams_pkg::ServoStep : '0;

  always_comb begin
    nxt = state_i;
    if (start_i) begin
      nxt.tick  = '0;
      nxt.z_dir = pams_pkg::Z_STOP;
      nxt.servo = cfg_i.servo_rest;
      nxt.phase = pams_pkg::PH_FWD;
    end else begin
      if (state_i.phase != pams_pkg::PH_IDLE) begin
        nxt.tick = tick_end ? '0 : tick_inc;
      end
      case (state_i.phase)
        pams_pkg::PH_FWD: begin
          nxt.z_dir = pams_pkg::Z_FWD;
          if (state_i.servo < up_bound) nxt.servo = up_val;
          if (tick_end) nxt.phase = pams_pkg::PH_GRIP;
        end
        pams_pkg::PH_GRIP: begin
          nxt.z_dir = pams_pkg::Z_STOP;
          if (state_i.servo > down_bound) nxt.servo = down_val;
          if (tick_end) nxt.phase = pams_pkg::PH_BACK;
        end
        pams_pkg::PH_BACK: begin
          nxt.z_dir = pams_pkg::Z_BACK;
          if (tick_end) nxt.phase = pams_pkg::PH_LIFT;
        end
        pams_pkg::PH_LIFT: begin
          nxt.z_dir = pams_pkg::Z_STOP;
          if (state_i.servo < up_bound) nxt.servo = up_val;
          if (tick_end) nxt.phase = pams_pkg::PH_REST;
        end
        pams_pkg::PH_REST: begin
          if (tick_end) begin
            nxt.z_dir = pams_pkg::Z_STOP;
            nxt.servo = cfg_i.servo_rest;
            nxt.phase = pams_pkg::PH_IDLE;
          end else if (state_i.servo > down_bound) begin
            nxt.servo = down_val;
          end
        end
        default: ;
      endcase
    end
  end

  assign state_o = nxt;

  assign res_o.servo_pwm = nxt.servo;
  assign res_o.z_pwm     = pams_pkg::z_compare(nxt.z_dir);
  assign res_o.z_dir     = nxt.z_dir;
  assign res_o.phase     = pams_pkg::phase_code(nxt.phase);
  assign res_o.busy      = nxt.phase != pams_pkg::PH_IDLE;

endmodule

@@ rtl/pick_arm_motion_sequencer_core.sv @@
// ---------------------------------------------------------------------------
// Pick arm motion sequencer core
// Steps the Z axis and gripper servo through a pick sequence, one tick per item.
// ---------------------------------------------------------------------------
// Each input item is one tick; start_pick_i set in an item starts or restarts
// the pick sequence. Every item yields exactly one result item carrying the
// servo compare, the Z compare and direction, the phase and a busy flag, all
// taken after that tick's update.
// The input item is captured in an input register, and the tick logic then
// loads the result register from it once the result register is free.
// One item is accepted per cycle as long as results are taken.
// When the receiver stalls, the result register holds its item and the input
// register holds one more; only then does in_ready_o drop. The sequence state
// advances only as an item moves into the result register.
// The configuration port always accepts writes and should only be written
// while no item is in flight. Reset restores the default bounds (max 1600,
// min 1400, rest 1500, pick time 14), puts the sequence idle with the servo
// at 1500 and Z stopped, and empties both registers.
// ---------------------------------------------------------------------------
module pick_arm_motion_sequencer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          start_pick_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pams_pkg::ServoW-1:0]   servo_pwm_o,
  output logic [pams_pkg::ZPwmW-1:0]    z_pwm_o,
  output logic [1:0]                    z_dir_o,
  output logic [pams_pkg::PhaseW-1:0]   phase_o,
  output logic                          busy_res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pams_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pams_pkg::CfgDatW-1:0]  cfg_data_i
);

  pams_pkg::cfg_t       cfg;
  pams_pkg::seq_state_t state_q, state_d;
  pams_pkg::result_t    res_q, res_d;
  logic                 in_valid_q, in_valid_d;
  logic                 start_q;
  logic                 out_valid_q, out_valid_d;
  logic                 advance;

  pams_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pams_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .start_i (start_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q.phase <= pams_pkg::PH_IDLE;
      state_q.tick  <= '0;
      state_q.servo <= pams_pkg::ServoRestRst;
      state_q.z_dir <= pams_pkg::Z_STOP;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      start_q <= start_pick_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign servo_pwm_o = res_q.servo_pwm;
  assign z_pwm_o     = res_q.z_pwm;
  assign z_dir_o     = res_q.z_dir;
  assign phase_o     = res_q.phase;
  assign busy_res_o  = res_q.busy;

endmodule

@@ tb/sv/tb_top.sv @@
// ---------------------------------------------------------------------------
// Pick arm motion sequencer core testbench
// Drives ticks with and without start requests through the item handshake,
// predicts each result item from its own model of the phase sequence or from
// a directed row, and compares each result field by field. Register settings
// are changed only while no item is in flight.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomTicks = 700;

  typedef logic [pams_pkg::CfgDatW-1:0] cfg_dat_t;
  typedef logic [pams_pkg::TickW-1:0]   tick_t;

  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          in_valid_i   = 1'b0;
  logic                          in_ready_o;
  logic                          start_pick_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i  = 1'b0;
  logic [pams_pkg::ServoW-1:0]   servo_pwm_o;
  logic [pams_pkg::ZPwmW-1:0]    z_pwm_o;
  logic [1:0]                    z_dir_o;
  logic [pams_pkg::PhaseW-1:0]   phase_o;
  logic                          busy_res_o;
  logic                          cfg_valid_i  = 1'b0;
  logic                          cfg_ready_o;
  logic [pams_pkg::CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [pams_pkg::CfgDatW-1:0]  cfg_data_i   = '0;

  pick_arm_motion_sequencer_core DUT (.*);

  always #10 clk_i = ~clk_i;

  // One row of the directed part: a register write or a tick.
  typedef struct packed {
    bit                 is_reg;
    pams_pkg::cfg_idx_e idx;
    cfg_dat_t           data;
    bit                 start;
    bit                 typed;
    pams_pkg::result_t  want;
  } plan_t;

  plan_t              plan_q[$];
  pams_pkg::result_t  expected_q[$];
  bit                 steady = 1'b0;
  int unsigned        n_items, n_ticks, n_results, n_errors, n_writes, n_settings;
  int unsigned        cycle_count;

  // Sequencer state and register copies used for prediction.
  logic [pams_pkg::ServoW-1:0] cfg_max, cfg_min, cfg_rest;
  logic [pams_pkg::PickW-1:0]  cfg_pick;
  logic [pams_pkg::PhaseW-1:0] ph;
  tick_t                       ticks;
  logic [pams_pkg::ServoW-1:0] servo;
  pams_pkg::z_dir_e            zd;

  function automatic void servo_up(logic [pams_pkg::ServoW-1:0] bound);
    logic [pams_pkg::ServoW:0] sum;
    if (servo < bound) begin
      sum = {1'b0, servo} + 12'd10;
      servo = (sum > 12'd2047) ? pams_pkg::ServoFull : sum[pams_pkg::ServoW-1:0];
    end
  endfunction

  function automatic void servo_down(logic [pams_pkg::ServoW-1:0] bound);
    if (servo > bound) begin
      servo = (servo >= pams_pkg::ServoStep) ? servo - pams_pkg::ServoStep : '0;
    end
  endfunction

  function automatic bit count_done(tick_t lim);
    ticks = ticks + 1'b1;
    if (ticks > lim) begin
      ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic pams_pkg::result_t next_motion(bit start);
    tick_t             travel;
    pams_pkg::result_t r;
    travel = tick_t'(cfg_pick) * 11'd5;
    if (start) begin
      ticks = '0;
      zd    = pams_pkg::Z_STOP;
      servo = cfg_rest;
      ph    = pams_pkg::PhaseCodeFwd;
    end else begin
      case (ph)
        pams_pkg::PhaseCodeFwd: begin
          zd = pams_pkg::Z_FWD;
          servo_up(cfg_max);
          if (count_done(travel)) ph = pams_pkg::PhaseCodeGrip;
        end
        pams_pkg::PhaseCodeGrip: begin
          zd = pams_pkg::Z_STOP;
          servo_down(cfg_min);
          if (count_done(pams_pkg::ShortLimit)) ph = pams_pkg::PhaseCodeBack;
        end
        pams_pkg::PhaseCodeBack: begin
          zd = pams_pkg::Z_BACK;
          if (count_done(travel)) ph = pams_pkg::PhaseCodeLift;
        end
        pams_pkg::PhaseCodeLift: begin
          zd = pams_pkg::Z_STOP;
          servo_up(cfg_max);
          if (count_done(pams_pkg::ShortLimit)) ph = pams_pkg::PhaseCodeRest;
        end
        pams_pkg::PhaseCodeRest: begin
          servo_down(cfg_rest);
          if (count_done(pams_pkg::ShortLimit)) begin
            zd    = pams_pkg::Z_STOP;
            servo = cfg_rest;
            ph    = pams_pkg::PhaseCodeIdle;
          end
        end
        default: ;
      endcase
    end
    r.servo_pwm = servo;
    r.z_pwm     = (zd == pams_pkg::Z_FWD)  ? pams_pkg::ZFwdCmp
                : (zd == pams_pkg::Z_BACK) ? pams_pkg::ZBackCmp : pams_pkg::ZStopCmp;
    r.z_dir     = zd;
    r.phase     = ph;
    r.busy      = (ph != pams_pkg::PhaseCodeIdle);
    return r;
  endfunction

  function automatic void add_reg(pams_pkg::cfg_idx_e idx, cfg_dat_t data);
    plan_t p;
    p        = '0;
    p.is_reg = 1'b1;
    p.idx    = idx;
    p.data   = data;
    plan_q.push_back(p);
  endfunction

  function automatic void add_tick(bit start);
    plan_t p;
    p       = '0;
    p.start = start;
    plan_q.push_back(p);
  endfunction

  function automatic void add_known(bit start, logic [pams_pkg::ServoW-1:0] sv,
                                    logic [pams_pkg::ZPwmW-1:0] zc,
                                    pams_pkg::z_dir_e dir,
                                    logic [pams_pkg::PhaseW-1:0] pc, bit busy);
    plan_t p;
    p       = '0;
    p.start = start;
    p.typed = 1'b1;
    p.want  = '{servo_pwm: sv, z_pwm: zc, z_dir: dir, phase: pc, busy: busy};
    plan_q.push_back(p);
  endfunction

  // Lower valid and let every result in flight drain out.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(pams_pkg::cfg_idx_e idx, cfg_dat_t data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      pams_pkg::CFG_SERVO_MAX:  cfg_max  = data;
      pams_pkg::CFG_SERVO_MIN:  cfg_min  = data;
      pams_pkg::CFG_PICK_TIME:  cfg_pick = data[pams_pkg::PickW-1:0];
      pams_pkg::CFG_SERVO_REST: cfg_rest = data;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic load_setting(cfg_dat_t mx, cfg_dat_t mn, cfg_dat_t pk, cfg_dat_t rs);
    write_reg(pams_pkg::CFG_SERVO_MAX, mx);
    write_reg(pams_pkg::CFG_SERVO_MIN, mn);
    write_reg(pams_pkg::CFG_PICK_TIME, pk);
    write_reg(pams_pkg::CFG_SERVO_REST, rs);
    n_settings++;
  endtask

  task automatic send_tick(bit start, bit typed, pams_pkg::result_t want);
    pams_pkg::result_t r;
    if (!steady && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 27);
    end
    in_valid_i   <= 1'b1;
    start_pick_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    if (start || ph != pams_pkg::PhaseCodeIdle) n_ticks++;
    r = next_motion(start);
    expected_q.push_back(typed ? want : r);
    n_items++;
  endtask

  // Mostly complete pick sequences; some are cut short by the next start,
  // and a stray restart now and then lands in the middle of a phase.
  task automatic run_sequences(int unsigned count);
    int unsigned full, len;
    repeat (count) begin
      repeat ($urandom_range(2, 0)) send_tick(1'b0, 1'b0, '0);
      send_tick(1'b1, 1'b0, '0);
      full = 2 * (5 * cfg_pick + 1) + 93;
      if ($urandom_range(99) < 75) len = full + $urandom_range(3, 0);
      else len = $urandom_range(full - 1, 1);
      repeat (len) send_tick($urandom_range(99) < 2, 1'b0, '0);
    end
  endtask

  task automatic random_setting();
    cfg_dat_t pk;
    pk = ($urandom_range(9, 0) == 0) ? cfg_dat_t'($urandom_range(30, 9))
                                     : cfg_dat_t'($urandom_range(8, 0));
    if ($urandom_range(99) < 70) begin
      load_setting(cfg_dat_t'($urandom_range(1750, 1500)),
                   cfg_dat_t'($urandom_range(1500, 1250)), pk,
                   cfg_dat_t'($urandom_range(2047, 0)));
    end else begin
      pk[pams_pkg::CfgDatW-1:pams_pkg::PickW] = 3'($urandom_range(7, 0));
      load_setting(cfg_dat_t'($urandom_range(2047, 0)),
                   cfg_dat_t'($urandom_range(2047, 0)), pk,
                   cfg_dat_t'($urandom_range(2047, 0)));
    end
  endtask

  task automatic flag(string field, logic [15:0] want, logic [15:0] got);
    n_errors++;
    if (n_errors <= 10)
      $display("result %0d: %s expected %0d, got %0d", n_results, field, want, got);
  endtask

  // Receiver side: random back-pressure except in the steady stretch.
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 27);
  end

  always @(posedge clk_i) begin : check_results
    pams_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (expected_q.size() == 0) begin
        flag("item with nothing expected", '0, '0);
      end else begin
        want = expected_q.pop_front();
        if (servo_pwm_o !== want.servo_pwm)
          flag("servo_pwm", 16'(want.servo_pwm), 16'(servo_pwm_o));
        if (z_pwm_o !== want.z_pwm) flag("z_pwm", 16'(want.z_pwm), 16'(z_pwm_o));
        if (z_dir_o !== want.z_dir) flag("z_dir", 16'(want.z_dir), 16'(z_dir_o));
        if (phase_o !== want.phase) flag("phase", 16'(want.phase), 16'(phase_o));
        if (busy_res_o !== want.busy) flag("busy_res", 16'(want.busy), 16'(busy_res_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timed out with %0d results still expected.", expected_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    cfg_max  = pams_pkg::ServoMaxRst;
    cfg_min  = pams_pkg::ServoMinRst;
    cfg_pick = pams_pkg::PickTimeRst;
    cfg_rest = pams_pkg::ServoRestRst;
    ph       = pams_pkg::PhaseCodeIdle;
    ticks    = '0;
    servo    = pams_pkg::ServoRestRst;
    zd       = pams_pkg::Z_STOP;

    // Idle after reset holds, then a start, the first forward step and a
    // restart in the middle of the forward travel.
    add_known(1'b0, 11'd1500, pams_pkg::ZStopCmp, pams_pkg::Z_STOP,
              pams_pkg::PhaseCodeIdle, 1'b0);
    add_known(1'b0, 11'd1500, pams_pkg::ZStopCmp, pams_pkg::Z_STOP,
              pams_pkg::PhaseCodeIdle, 1'b0);
    add_known(1'b1, 11'd1500, pams_pkg::ZStopCmp, pams_pkg::Z_STOP,
              pams_pkg::PhaseCodeFwd, 1'b1);
    add_known(1'b0, 11'd1510, pams_pkg::ZFwdCmp, pams_pkg::Z_FWD,
              pams_pkg::PhaseCodeFwd, 1'b1);
    add_tick(1'b0);
    add_tick(1'b0);
    add_known(1'b1, 11'd1500, pams_pkg::ZStopCmp, pams_pkg::Z_STOP,
              pams_pkg::PhaseCodeFwd, 1'b1);
    add_tick(1'b0);
    // Ramp up saturating at the top of the field; pick time of zero with the
    // unused upper data bits set.
    add_reg(pams_pkg::CFG_SERVO_MAX, 11'd2047);
    add_reg(pams_pkg::CFG_SERVO_MIN, 11'd0);
    add_reg(pams_pkg::CFG_PICK_TIME, 11'h700);
    add_reg(pams_pkg::CFG_SERVO_REST, 11'd2045);
    add_known(1'b1, 11'd2045, pams_pkg::ZStopCmp, pams_pkg::Z_STOP,
              pams_pkg::PhaseCodeFwd, 1'b1);
    repeat (5) add_tick(1'b0);
    // Ramp down from 5 toward a bound of 0 saturates at zero.
    add_reg(pams_pkg::CFG_SERVO_MAX, 11'd0);
    add_reg(pams_pkg::CFG_PICK_TIME, 11'd1);
    add_reg(pams_pkg::CFG_SERVO_REST, 11'd5);
    add_known(1'b1, 11'd5, pams_pkg::ZStopCmp, pams_pkg::Z_STOP,
              pams_pkg::PhaseCodeFwd, 1'b1);
    repeat (9) add_tick(1'b0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_reg) write_reg(plan_q[i].idx, plan_q[i].data);
      else send_tick(plan_q[i].start, plan_q[i].typed, plan_q[i].want);
    end

    n_ticks = 0;
    while (n_ticks < RandomTicks) begin
      case (n_settings)
        0: begin
          load_setting(11'd0, 11'd0, 11'd0, 11'd0);
          run_sequences($urandom_range(4, 2));
        end
        1: begin
          // Default bounds with neither side idling.
          load_setting(pams_pkg::ServoMaxRst, pams_pkg::ServoMinRst,
                       cfg_dat_t'(pams_pkg::PickTimeRst), pams_pkg::ServoRestRst);
          steady = 1'b1;
          run_sequences(1);
          steady = 1'b0;
        end
        default: begin
          random_setting();
          run_sequences(1);
        end
      endcase
    end

    // Every register at the top of its field, with a restart partway through
    // the long forward travel.
    load_setting(11'd2047, 11'd2047, 11'd255, 11'd2047);
    send_tick(1'b1, 1'b0, '0);
    repeat (30) send_tick(1'b0, 1'b0, '0);
    send_tick(1'b1, 1'b0, '0);
    repeat (30) send_tick(1'b0, 1'b0, '0);

    settle();
    $display("Checked %0d result items from %0d ticks, %0d of them inside a sequence.",
             n_results, n_items, n_ticks);
    $display("Used %0d register settings over %0d writes, field extremes included.",
             n_settings, n_writes);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching fields in total.", n_errors);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
